@@ design/cla_pkg.sv @@
package cla_pkg;

   localparam int VTX_W   = 12;
   localparam int COORD_W = 24;
   localparam int VAL_W   = 48;
   localparam int TERM_W  = 47;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic KIND_OFF  = 1'b0;
   localparam logic KIND_DIAG = 1'b1;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic                      opcode;
      logic [VTX_W-1:0]          row_vertex;
      logic [VTX_W-1:0]          col_vertex;
      logic signed [COORD_W-1:0] x_i;
      logic signed [COORD_W-1:0] y_i;
      logic signed [COORD_W-1:0] x_k;
      logic signed [COORD_W-1:0] y_k;
      logic signed [COORD_W-1:0] x_opp_a;
      logic signed [COORD_W-1:0] y_opp_a;
      logic signed [COORD_W-1:0] x_opp_b;
      logic signed [COORD_W-1:0] y_opp_b;
      logic [1:0]                boundary_sides;
   } req_type;

   typedef struct packed {
      logic                    entry_kind;
      logic [VTX_W-1:0]        row;
      logic [VTX_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [TERM_W-1:0] term;
   } lane_res_type;

endpackage

@@ design/cla_lane.sv @@
module cla_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [cla_pkg::COORD_W-1:0] xi,
   input  logic signed [cla_pkg::COORD_W-1:0] yi,
   input  logic signed [cla_pkg::COORD_W-1:0] xk,
   input  logic signed [cla_pkg::COORD_W-1:0] yk,
   input  logic signed [cla_pkg::COORD_W-1:0] xo,
   input  logic signed [cla_pkg::COORD_W-1:0] yo,
   output cla_pkg::lane_res_type              res
);
   import cla_pkg::*;

   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int ADOT_W = PROD_W - 1;
   localparam int DEN_W  = PROD_W;
   localparam int NUM_W  = ADOT_W + FRAC_BITS;
   localparam int HI_W   = NUM_W - TERM_W;
   localparam int CNT_W  = $clog2(TERM_W + 1);

   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_MUL  = 3'd1;
   localparam logic [2:0] L_SUM  = 3'd2;
   localparam logic [2:0] L_PREP = 3'd3;
   localparam logic [2:0] L_DIV  = 3'd4;
   localparam logic [2:0] L_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [DIFF_W-1:0] dix_ff, diy_ff, dkx_ff, dky_ff;
   logic signed [PROD_W-1:0] p_xx_ff, p_yy_ff, p_xy_ff, p_yx_ff;
   logic signed [SUM_W-1:0]  dot_ff, cross_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [DEN_W-1:0]         rem_ff;
   logic [TERM_W-1:0]        low_ff, q_ff;
   logic                     sat_ff;

   logic [SUM_W-1:0]  abs_dot, abs_cross;
   logic [NUM_W-1:0]  num;
   logic [DEN_W-1:0]  hi_ext, den_new;
   logic [DEN_W:0]    rem_try;
   logic [DEN_W:0]    rem_sub;
   logic              take;

   always_comb begin
      abs_dot   = dot_ff[SUM_W-1] ? SUM_W'(-dot_ff) : SUM_W'(dot_ff);
      abs_cross = cross_ff[SUM_W-1] ? SUM_W'(-cross_ff) : SUM_W'(cross_ff);
      num       = {abs_dot[ADOT_W-1:0], {FRAC_BITS{1'b0}}};
      hi_ext    = DEN_W'(num[NUM_W-1:TERM_W]);
      den_new   = {abs_cross[ADOT_W-1:0], 1'b0};
      rem_try   = {rem_ff, low_ff[TERM_W-1]};
      rem_sub   = rem_try - {1'b0, den_ff};
      take      = (rem_try >= {1'b0, den_ff});
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         L_IDLE, L_DONE: begin
            if (start) begin
               state_in = L_MUL;
            end
         end
         L_MUL:  state_in = L_SUM;
         L_SUM:  state_in = L_PREP;
         L_PREP: begin
            state_in = L_DIV;
            cnt_in   = '0;
         end
         L_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TERM_W - 1)) begin
               state_in = L_DONE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dix_ff <= DIFF_W'(xi) - DIFF_W'(xo);
         diy_ff <= DIFF_W'(yi) - DIFF_W'(yo);
         dkx_ff <= DIFF_W'(xk) - DIFF_W'(xo);
         dky_ff <= DIFF_W'(yk) - DIFF_W'(yo);
      end
      if (state_ff == L_MUL) begin
         p_xx_ff <= dix_ff * dkx_ff;
         p_yy_ff <= diy_ff * dky_ff;
         p_xy_ff <= dix_ff * dky_ff;
         p_yx_ff <= diy_ff * dkx_ff;
      end
      if (state_ff == L_SUM) begin
         dot_ff   <= SUM_W'(p_xx_ff) + SUM_W'(p_yy_ff);
         cross_ff <= SUM_W'(p_xy_ff) - SUM_W'(p_yx_ff);
      end
      if (state_ff == L_PREP) begin
         den_ff <= den_new;
         sat_ff <= (hi_ext >= den_new);
         rem_ff <= hi_ext;
         low_ff <= num[TERM_W-1:0];
         q_ff   <= '0;
      end
      if (state_ff == L_DIV) begin
         rem_ff <= take ? rem_sub[DEN_W-1:0] : rem_try[DEN_W-1:0];
         low_ff <= {low_ff[TERM_W-2:0], 1'b0};
         q_ff   <= {q_ff[TERM_W-2:0], take};
      end
   end

   assign res.done = (state_ff == L_DONE);
   assign res.term = sat_ff ? {TERM_W{1'b1}} : q_ff;

endmodule

@@ design/cotan_laplacian_assembly.sv @@
// Add item: both sides run side by side in two lanes, each with a 47-step
// quotient loop; each item is finished before the next input is taken. Read
// item: the stored diagonal entry is read, returned and cleared. A held-off
// result stalls input. Reset (synchronous) starts a clear pass over all
// min(VERTEX_COUNT, 4096) entries of the diagonal store, during which no item
// is taken.
module cotan_laplacian_assembly #(
   parameter int VERTEX_COUNT     = 4096,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cla_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cla_pkg::rsp_type rsp_data
);
   import cla_pkg::*;

   localparam int DEPTH = (VERTEX_COUNT > (1 << VTX_W)) ? (1 << VTX_W) : VERTEX_COUNT;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RUN   = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   req_type       item_ff;
   logic [VAL_W-1:0] sum_ff, sum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic signed [VAL_W-1:0] diag_mem [DEPTH];
   logic signed [VAL_W-1:0] mem_rd_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic signed [VAL_W-1:0] wr_data;

   lane_res_type  res_a, res_b;
   logic          accept, lane_start, out_free, item_in_store;
   logic [TERM_W-1:0] ta, tb;
   logic [VAL_W-1:0]  tsum;
   logic signed [VAL_W:0] dnew;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign lane_start = accept && (req_data.opcode == OP_ADD);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign item_in_store = (32'(item_ff.row_vertex) < VERTEX_COUNT);

   cla_lane #(.FRAC_BITS(WEIGHT_FRAC_BITS)) u_lane_a (
      .clock(clock), .reset(reset), .start(lane_start),
      .xi(req_data.x_i), .yi(req_data.y_i), .xk(req_data.x_k), .yk(req_data.y_k),
      .xo(req_data.x_opp_a), .yo(req_data.y_opp_a), .res(res_a)
   );

   cla_lane #(.FRAC_BITS(WEIGHT_FRAC_BITS)) u_lane_b (
      .clock(clock), .reset(reset), .start(lane_start),
      .xi(req_data.x_i), .yi(req_data.y_i), .xk(req_data.x_k), .yk(req_data.y_k),
      .xo(req_data.x_opp_b), .yo(req_data.y_opp_b), .res(res_b)
   );

   always_comb begin
      ta   = item_ff.boundary_sides[0] ? '0 : res_a.term;
      tb   = item_ff.boundary_sides[1] ? '0 : res_b.term;
      tsum = VAL_W'(ta) + VAL_W'(tb);
      if (tsum[VAL_W-1]) begin
         tsum = VAL_MAX;
      end
      dnew = {mem_rd_ff[VAL_W-1], mem_rd_ff} - {1'b0, sum_ff};
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = item_ff.row_vertex[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = item_ff.row_vertex[AW-1:0];
      wr_data      = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rd_en   = 1'b1;
               rd_addr = req_data.row_vertex[AW-1:0];
               state_in = (req_data.opcode == OP_READ) ? S_RD : S_RUN;
            end
         end
         S_RUN: begin
            if (res_a.done && res_b.done) begin
               rd_en    = 1'b1;
               sum_in   = tsum;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (sum_ff == '0) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               wr_en   = item_in_store;
               wr_data = (dnew[VAL_W] != dnew[VAL_W-1]) ? VAL_MIN : dnew[VAL_W-1:0];
               rsp_valid_in           = 1'b1;
               rsp_data_in.entry_kind = KIND_OFF;
               rsp_data_in.row        = item_ff.row_vertex;
               rsp_data_in.col        = item_ff.col_vertex;
               rsp_data_in.value      = sum_ff;
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            if (out_free) begin
               wr_en   = item_in_store;
               rsp_valid_in           = 1'b1;
               rsp_data_in.entry_kind = KIND_DIAG;
               rsp_data_in.row        = item_ff.row_vertex;
               rsp_data_in.col        = item_ff.row_vertex;
               rsp_data_in.value      = item_in_store ? mem_rd_ff : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         diag_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= diag_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      res_a.done == res_b.done)
      else $error("lanes out of step");
   a_diag_on_diagonal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_kind == KIND_DIAG |-> rsp_data.row == rsp_data.col)
      else $error("diagonal entry off the diagonal");
   a_off_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_kind == KIND_OFF |-> rsp_data.value > 0)
      else $error("off-diagonal entry not positive");
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("transfer during clear pass");
`endif

endmodule

@@ tb/cla_checker.sv @@
`timescale 1ns / 100ps

module cla_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cla_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cla_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import cla_pkg::*;

   localparam int FRAC = 16;
   localparam int NVTX = 4096;

   logic signed [VAL_W-1:0] diag_store [NVTX];
   rsp_type entry_q[$];

   function automatic logic signed [VAL_W-1:0] cot_term(
      logic signed [COORD_W-1:0] xi, logic signed [COORD_W-1:0] yi,
      logic signed [COORD_W-1:0] xk, logic signed [COORD_W-1:0] yk,
      logic signed [COORD_W-1:0] xo, logic signed [COORD_W-1:0] yo);
      longint dix, diy, dkx, dky, dotp, crs;
      logic [127:0] num, den, q;
      dix = longint'(xi) - longint'(xo);
      diy = longint'(yi) - longint'(yo);
      dkx = longint'(xk) - longint'(xo);
      dky = longint'(yk) - longint'(yo);
      dotp = dix * dkx + diy * dky;
      crs = dix * dky - diy * dkx;
      if (dotp < 0) dotp = -dotp;
      if (crs < 0) crs = -crs;
      if (crs == 0) return VAL_MAX;
      num = 128'(dotp) << FRAC;
      den = 128'(crs) * 2;
      q = num / den;
      if (q > 128'(VAL_MAX)) return VAL_MAX;
      return q[VAL_W-1:0];
   endfunction

   task automatic predict_entry(input req_type r);
      rsp_type e;
      logic signed [VAL_W-1:0] sum, t;
      logic signed [VAL_W+1:0] d;
      if (r.opcode == OP_READ) begin
         e.entry_kind = KIND_DIAG;
         e.row = r.row_vertex;
         e.col = r.row_vertex;
         e.value = diag_store[r.row_vertex];
         diag_store[r.row_vertex] = '0;
         entry_q = {entry_q, e};
         return;
      end
      sum = '0;
      if (!r.boundary_sides[0])
         sum = cot_term(r.x_i, r.y_i, r.x_k, r.y_k, r.x_opp_a, r.y_opp_a);
      if (!r.boundary_sides[1]) begin
         t = cot_term(r.x_i, r.y_i, r.x_k, r.y_k, r.x_opp_b, r.y_opp_b);
         sum = (sum > VAL_MAX - t) ? VAL_MAX : sum + t;
      end
      if (sum == 0) return;
      d = (VAL_W+2)'(diag_store[r.row_vertex]) - (VAL_W+2)'(sum);
      diag_store[r.row_vertex] = (d < (VAL_W+2)'(VAL_MIN)) ? VAL_MIN : d[VAL_W-1:0];
      e.entry_kind = KIND_OFF;
      e.row = r.row_vertex;
      e.col = r.col_vertex;
      e.value = sum;
      entry_q = {entry_q, e};
   endtask

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      foreach (diag_store[i]) diag_store[i] = '0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (entry_q.size() == 0) begin
               report($sformatf("unexpected transfer %p", rsp_data));
            end else begin
               want = entry_q.pop_front();
               if (rsp_data.entry_kind !== want.entry_kind)
                  report($sformatf("kind %0d want %0d", rsp_data.entry_kind, want.entry_kind));
               if (rsp_data.row !== want.row)
                  report($sformatf("row %0d want %0d", rsp_data.row, want.row));
               if (rsp_data.col !== want.col)
                  report($sformatf("col %0d want %0d", rsp_data.col, want.col));
               if (rsp_data.value !== want.value)
                  report($sformatf("value %0d want %0d", rsp_data.value, want.value));
            end
         end
         if (req_valid && req_ready) predict_entry(req_data);
      end
      pending = entry_q.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import cla_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending;
   int      hold_off = 0;
   bit      stall_req = 0;
   bit      stall_done = 0;
   bit      drain_now = 0;

   always #6 clock = ~clock;

   cotan_laplacian_assembly dut (.*);

   cla_checker checker_i (.*);

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(input int mode);
      case (mode)
         0: return COORD_W'($urandom);
         1: return COORD_W'($signed($urandom_range(0, 16384)) - 8192);
         2: return {1'b1, {(COORD_W-1){1'b0}}};
         default: return {1'b0, {(COORD_W-1){1'b1}}};
      endcase
   endfunction

   task automatic send(input req_type r);
      int g;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic req_type edge_item(input logic [VTX_W-1:0] v, input int mode,
                                         input logic [1:0] bs);
      req_type r;
      r.opcode = OP_ADD;
      r.row_vertex = v;
      r.col_vertex = VTX_W'($urandom);
      r.x_i = rand_coord(mode);   r.y_i = rand_coord(mode);
      r.x_k = rand_coord(mode);   r.y_k = rand_coord(mode);
      r.x_opp_a = rand_coord(mode); r.y_opp_a = rand_coord(mode);
      r.x_opp_b = rand_coord(mode); r.y_opp_b = rand_coord(mode);
      r.boundary_sides = bs;
      return r;
   endfunction

   function automatic req_type read_item(input logic [VTX_W-1:0] v);
      req_type r;
      r = edge_item(v, 0, 2'($urandom));
      r.opcode = OP_READ;
      return r;
   endfunction

   always @(posedge clock) begin
      if (stall_req && !stall_done) begin
         stall_done <= 1'b1;
         hold_off <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0) || drain_now;
      end
   end

   initial begin
      #20ms;
      $display("tb failed");
      $finish;
   end

   initial begin
      req_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: right triangle, degenerate, boundary combinations, extremes
      r = edge_item(12'd5, 1, 2'b00);
      r.x_i = 24'sd0; r.y_i = 24'sd0; r.x_k = 24'sd4096; r.y_k = 24'sd0;
      r.x_opp_a = 24'sd0; r.y_opp_a = 24'sd4096;
      r.x_opp_b = 24'sd2048; r.y_opp_b = -24'sd4096;
      send(r);
      r.boundary_sides = 2'b01; send(r);
      r.boundary_sides = 2'b10; send(r);
      r.boundary_sides = 2'b11; send(r);
      r.boundary_sides = 2'b00; r.x_opp_a = 24'sd8192; r.y_opp_a = 24'sd0; send(r);
      r.x_opp_b = 24'sd8192; r.y_opp_b = 24'sd0; send(r);
      r.x_opp_a = 24'sd2048; r.y_opp_a = 24'sd4096;
      r.x_opp_b = 24'sd2048; r.y_opp_b = -24'sd4096; send(r);
      send(read_item(12'd5));
      send(read_item(12'd5));
      send(edge_item(12'd0, 2, 2'b00));
      send(edge_item(12'd4095, 3, 2'b00));
      r = edge_item(12'd4095, 3, 2'b00); r.x_k = {1'b1, 23'd0}; r.y_k = {1'b1, 23'd0};
      send(r);
      for (int i = 0; i < 4; i++) send(edge_item(12'd4095, 1, 2'(i)));
      send(edge_item(12'd0, 0, 2'b00));
      send(read_item(12'd0));
      send(read_item(12'd4095));
      send(read_item(12'd77));
      // sender pauses until everything is back
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      // receiver holds off while items keep coming
      stall_req = 1'b1;
      for (int i = 0; i < 8; i++) send(edge_item(12'($urandom_range(0, 7)), 1, 2'b00));
      for (int n = 0; n < 780; n++) begin
         int p;
         p = $urandom_range(0, 99);
         if (p < 20)
            send(read_item(12'($urandom_range(0, 15))));
         else if (p < 85)
            send(edge_item(12'($urandom_range(0, 15)), 1, 2'($urandom_range(0, 3))));
         else
            send(edge_item(VTX_W'($urandom), $urandom_range(0, 3), 2'($urandom)));
      end
      for (int v = 0; v < 16; v++) send(read_item(12'(v)));
      req_valid <= 1'b0;
      drain_now = 1;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
